@@ rtl/csm_pkg.sv @@
// Package for the checked stack machine: opcodes, widths and shared command/status types.
package csm_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int VAL_W       = 31;
    localparam int MAG_W       = 30;
    localparam logic signed [62:0] VALUE_LIMIT = 63'sd1000000000;

    typedef enum logic [3:0] {
        OP_START = 4'd0,
        OP_NUM   = 4'd1,
        OP_POP   = 4'd2,
        OP_INV   = 4'd3,
        OP_DUP   = 4'd4,
        OP_SWP   = 4'd5,
        OP_ADD   = 4'd6,
        OP_SUB   = 4'd7,
        OP_MUL   = 4'd8,
        OP_DIV   = 4'd9,
        OP_MOD   = 4'd10,
        OP_END   = 4'd11
    } op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;        // reset count and error
        logic latch_err;    // set error flag
        logic rd_top;       // read entry count-1
        logic rd_second;    // read entry count-2
        logic cap_b;        // capture read data as b
        logic cap_a;        // capture read data as a
        logic wr_operand;   // write operand at count
        logic wr_neg;       // write -b at count-1
        logic wr_b_dup;     // write b at count
        logic wr_swap_lo;   // write b at count-2
        logic wr_swap_hi;   // write a at count-1
        logic inc;          // count += 1
        logic dec;          // count -= 1
        logic dec2;         // count -= 2
        logic compute;      // register arithmetic result
        logic div_start;    // start divider
        logic push_res;     // push arithmetic result (or error if too large)
        logic emit;         // load output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic err;
        logic cnt_ge1;
        logic cnt_ge2;
        logic full;
        logic opnd_big;
        logic b_zero;
        logic div_done;
    } stat_t;

endpackage

@@ rtl/csm_ram.sv @@
// Generic single-port RAM with registered read.
module csm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end
    assign rdata = rdata_reg;
endmodule

@@ rtl/csm_div.sv @@
// Radix-2 restoring divider on 32-bit magnitudes with signed fix-up (truncating).
module csm_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic signed [csm_pkg::VAL_W-1:0] dividend,
    input  logic signed [csm_pkg::VAL_W-1:0] divisor,
    output logic                             done,
    output logic signed [csm_pkg::VAL_W:0]   quot,
    output logic signed [csm_pkg::VAL_W:0]   rem
);
    localparam int M = csm_pkg::VAL_W + 1;
    localparam int CW = $clog2(M + 1);

    logic [M-1:0] q_reg, q_next, d_reg, d_next, r_reg, r_next;
    logic         qn_reg, qn_next, rn_reg, rn_next, busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [M:0]   trial;
    logic [M-1:0] a_mag, b_mag;

    always_comb begin
        a_mag = dividend[M-2] ? M'(-signed'({dividend[M-2], dividend})) : M'({1'b0, dividend});
        b_mag = divisor[M-2] ? M'(-signed'({divisor[M-2], divisor})) : M'({1'b0, divisor});
        q_next = q_reg; d_next = d_reg; r_next = r_reg;
        qn_next = qn_reg; rn_next = rn_reg; busy_next = busy_reg; cnt_next = cnt_reg;
        trial = {r_reg, q_reg[M-1]} - {1'b0, d_reg};
        if (start) begin
            q_next = a_mag; d_next = b_mag; r_next = '0;
            qn_next = dividend[M-2] ^ divisor[M-2];
            rn_next = dividend[M-2];
            busy_next = 1'b1; cnt_next = CW'(M);
        end else if (busy_reg) begin
            if (!trial[M]) begin
                r_next = trial[M-1:0];
                q_next = {q_reg[M-2:0], 1'b1};
            end else begin
                r_next = {r_reg[M-2:0], q_reg[M-1]};
                q_next = {q_reg[M-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next; d_reg <= d_next; r_reg <= r_next;
        qn_reg <= qn_next; rn_reg <= rn_next;
    end

    assign done = !busy_reg;
    assign quot = qn_reg ? -signed'(q_reg) : signed'(q_reg);
    assign rem  = rn_reg ? -signed'(r_reg) : signed'(r_reg);
endmodule

@@ rtl/csm_datapath.sv @@
// Datapath: stack RAM, count and error registers, operand latches, ALU and divider.
module csm_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  csm_pkg::cmd_t                    cmd,
    input  logic [3:0]                       op,
    input  logic signed [csm_pkg::VAL_W-1:0] operand,
    output csm_pkg::stat_t                   stat,
    output logic signed [csm_pkg::VAL_W-1:0] out_value,
    output logic                             out_error
);
    localparam int AW = csm_pkg::ADDR_W;
    localparam int CW = csm_pkg::CNT_W;
    localparam int VW = csm_pkg::VAL_W;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          err_reg, err_next;
    logic signed [VW-1:0] a_reg, b_reg;
    logic signed [62:0]   res_reg, res_next;
    logic signed [VW-1:0] val_reg, val_next;
    logic                 oerr_reg, oerr_next;
    logic                 we;
    logic [CW-1:0]        addr_c;
    logic [VW-1:0]        wdata, rdata;
    logic                 div_done;
    logic signed [VW:0]   quot, rem;
    logic                 res_big;

    always_comb begin
        we = 1'b0; addr_c = cnt_reg - 1'b1; wdata = operand;
        if (cmd.rd_top) addr_c = cnt_reg - 1'b1;
        if (cmd.rd_second) addr_c = cnt_reg - CW'(2);
        if (cmd.wr_operand) begin
            // START empties the stack first, so its value lands at the bottom.
            we = 1'b1; addr_c = cmd.clear ? '0 : cnt_reg; wdata = operand;
        end
        if (cmd.wr_neg) begin
            we = 1'b1; addr_c = cnt_reg - 1'b1; wdata = -b_reg;
        end
        if (cmd.wr_b_dup) begin
            we = 1'b1; addr_c = cnt_reg; wdata = b_reg;
        end
        if (cmd.wr_swap_lo) begin
            we = 1'b1; addr_c = cnt_reg - CW'(2); wdata = b_reg;
        end
        if (cmd.wr_swap_hi) begin
            we = 1'b1; addr_c = cnt_reg - 1'b1; wdata = a_reg;
        end
        if (cmd.push_res && !res_big) begin
            we = 1'b1; addr_c = cnt_reg; wdata = res_reg[VW-1:0];
        end
    end

    csm_ram #(.WIDTH(VW), .DEPTH(csm_pkg::STACK_DEPTH)) u_ram (
        .aclk(aclk), .we(we), .addr(addr_c[AW-1:0]), .wdata(wdata), .rdata(rdata)
    );

    csm_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .dividend(a_reg), .divisor(b_reg), .done(div_done), .quot(quot), .rem(rem)
    );

    assign res_big = (res_reg > csm_pkg::VALUE_LIMIT) || (res_reg < -csm_pkg::VALUE_LIMIT);

    always_comb begin
        cnt_next = cnt_reg; err_next = err_reg;
        if (cmd.clear) begin
            cnt_next = '0; err_next = 1'b0;
        end
        if (cmd.inc) cnt_next = cnt_next + 1'b1;
        if (cmd.dec) cnt_next = cnt_reg - 1'b1;
        if (cmd.dec2) cnt_next = cnt_reg - CW'(2);
        if (cmd.latch_err) err_next = 1'b1;
        if (cmd.push_res) begin
            if (res_big) err_next = 1'b1;
            else cnt_next = cnt_reg + 1'b1;
        end
        res_next = res_reg;
        if (cmd.compute) begin
            case (op)
                csm_pkg::OP_ADD: res_next = 63'(a_reg) + 63'(b_reg);
                csm_pkg::OP_SUB: res_next = 63'(a_reg) - 63'(b_reg);
                csm_pkg::OP_MUL: res_next = 63'(a_reg) * 63'(b_reg);
                csm_pkg::OP_DIV: res_next = 63'(quot);
                default:         res_next = 63'(rem);
            endcase
        end
        val_next = val_reg; oerr_next = oerr_reg;
        if (cmd.emit) begin
            oerr_next = err_reg || (cnt_reg != CW'(1));
            val_next  = oerr_next ? '0 : rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            err_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            err_reg <= err_next;
        end
        if (cmd.cap_b) b_reg <= rdata;
        if (cmd.cap_a) a_reg <= rdata;
        res_reg  <= res_next;
        val_reg  <= val_next;
        oerr_reg <= oerr_next;
    end

    assign stat.err      = err_reg;
    assign stat.cnt_ge1  = cnt_reg >= CW'(1);
    assign stat.cnt_ge2  = cnt_reg >= CW'(2);
    assign stat.full     = cnt_reg >= CW'(csm_pkg::STACK_DEPTH);
    assign stat.opnd_big = (63'(operand) > csm_pkg::VALUE_LIMIT)
                           || (63'(operand) < -csm_pkg::VALUE_LIMIT);
    assign stat.b_zero   = b_reg == '0;
    assign stat.div_done = div_done;
    assign out_value = val_reg;
    assign out_error = oerr_reg;
endmodule

@@ rtl/csm_ctrl.sv @@
// Controller: sequences each instruction through stack reads, arithmetic and write-back.
module csm_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [3:0]     s_req_type,
    output logic [3:0]     op,
    input  csm_pkg::stat_t stat,
    output csm_pkg::cmd_t  cmd,
    output logic           m_valid,
    input  logic           m_ready
);
    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_RDB   = 10'b0000000010,
        ST_CAPB  = 10'b0000000100,
        ST_CAPA  = 10'b0000001000,
        ST_EXEC  = 10'b0000010000,
        ST_DIVW  = 10'b0000100000,
        ST_PUSH  = 10'b0001000000,
        ST_EMITR = 10'b0010000000,
        ST_EMIT  = 10'b0100000000,
        ST_CALC  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [3:0] op_reg, op_next;
    logic m_valid_reg, m_valid_next;

    assign op = op_reg;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg; op_next = op_reg; cmd = '0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    op_next = s_req_type;
                    case (s_req_type)
                        csm_pkg::OP_START: begin
                            cmd.clear = 1'b1;
                            if (stat.opnd_big) cmd.latch_err = 1'b1;
                            else begin
                                cmd.inc = 1'b1; cmd.wr_operand = 1'b1;
                            end
                        end
                        csm_pkg::OP_END: begin
                            cmd.rd_top = 1'b1; state_next = ST_EMITR;
                        end
                        csm_pkg::OP_NUM: begin
                            if (!stat.err) begin
                                if (stat.opnd_big || stat.full) cmd.latch_err = 1'b1;
                                else begin
                                    cmd.inc = 1'b1; cmd.wr_operand = 1'b1;
                                end
                            end
                        end
                        csm_pkg::OP_POP, csm_pkg::OP_INV, csm_pkg::OP_DUP: begin
                            if (!stat.err) begin
                                if (!stat.cnt_ge1) cmd.latch_err = 1'b1;
                                else if (s_req_type == csm_pkg::OP_POP) cmd.dec = 1'b1;
                                else begin
                                    cmd.rd_top = 1'b1; state_next = ST_CAPB;
                                end
                            end
                        end
                        csm_pkg::OP_SWP, csm_pkg::OP_ADD, csm_pkg::OP_SUB,
                        csm_pkg::OP_MUL, csm_pkg::OP_DIV, csm_pkg::OP_MOD: begin
                            if (!stat.err) begin
                                if (!stat.cnt_ge2) cmd.latch_err = 1'b1;
                                else begin
                                    cmd.rd_top = 1'b1; state_next = ST_RDB;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_CAPB: begin
                cmd.cap_b = 1'b1; state_next = ST_EXEC;
            end
            ST_EXEC: begin
                state_next = ST_IDLE;
                if (op_reg == csm_pkg::OP_INV) cmd.wr_neg = 1'b1;
                else if (stat.full) cmd.latch_err = 1'b1;
                else begin
                    cmd.wr_b_dup = 1'b1; cmd.inc = 1'b1;
                end
            end
            ST_RDB: begin
                cmd.cap_b = 1'b1; cmd.rd_second = 1'b1; state_next = ST_CAPA;
            end
            ST_CAPA: begin
                cmd.cap_a = 1'b1; state_next = ST_CALC;
            end
            ST_CALC: begin
                case (op_reg)
                    csm_pkg::OP_SWP: begin
                        cmd.wr_swap_lo = 1'b1; state_next = ST_PUSH;
                    end
                    csm_pkg::OP_DIV, csm_pkg::OP_MOD: begin
                        if (stat.b_zero) begin
                            cmd.latch_err = 1'b1; cmd.dec2 = 1'b1; state_next = ST_IDLE;
                        end else begin
                            cmd.div_start = 1'b1; state_next = ST_DIVW;
                        end
                    end
                    default: begin
                        cmd.compute = 1'b1; cmd.dec2 = 1'b1; state_next = ST_PUSH;
                    end
                endcase
            end
            ST_DIVW: begin
                if (stat.div_done) begin
                    cmd.compute = 1'b1; cmd.dec2 = 1'b1; state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (op_reg == csm_pkg::OP_SWP) cmd.wr_swap_hi = 1'b1;
                else cmd.push_res = 1'b1;
                state_next = ST_IDLE;
            end
            ST_EMITR: state_next = ST_EMIT;
            ST_EMIT: begin
                // Hold here while an earlier result word still occupies the output.
                if (!m_valid_reg || m_ready) begin
                    cmd.emit = 1'b1; m_valid_next = 1'b1; state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg <= op_next;
    end
endmodule

@@ rtl/checked_stack_machine_core.sv @@
// Top level of the checked stack machine: controller plus datapath.
// The core executes one stack-machine instruction per input word. START, NUM,
// POP and undefined codes finish in the idle state; INV and DUP step through
// CAPB and EXEC; SWP, ADD, SUB and MUL step through RDB, CAPA, CALC and PUSH;
// DIV and MOD also wait in DIVW on the one-bit-per-cycle restoring divider
// over 32 quotient bits, or go back to idle from CALC when the divisor is
// zero; END steps through EMITR and EMIT, and waits in EMIT for as long as an
// earlier result word is still held on the output. Stack entries live in a
// 1024-entry single-port RAM with a registered read. Once an error is latched
// every instruction other than START and END is ignored. END produces one
// result word carrying the sole stack value, or error set and a zero value
// when the stack does not hold exactly one entry or an error has been latched.
// Words are still accepted while a result word waits on the output; only a
// following END stalls until that word has been taken.
module checked_stack_machine_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [3:0]                       s_req_type,
    input  logic signed [csm_pkg::VAL_W-1:0] s_operand,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [csm_pkg::VAL_W-1:0] m_result_value,
    output logic                             m_error
);
    csm_pkg::cmd_t  cmd;
    csm_pkg::stat_t stat;
    logic [3:0]     op;

    csm_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_req_type(s_req_type), .op(op), .stat(stat), .cmd(cmd),
        .m_valid(m_valid), .m_ready(m_ready)
    );

    csm_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .op(op), .operand(s_operand),
        .stat(stat), .out_value(m_result_value), .out_error(m_error)
    );
endmodule
